[hw/rtl/spc_pkg.sv]
// shared types and constants for the stepper position controller
// no dependencies; used by every module of the block
package spc_pkg;

  localparam int unsigned POS_W     = 32;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [TICK_W-1:0] MIN_PERIOD_TICKS = TICK_W'(64);
  localparam logic [TICK_W-1:0] PERIOD_RESET     = TICK_W'(1000);
  localparam logic [TICK_W-1:0] HIGH_RESET       = TICK_W'(100);

  // command codes
  localparam logic [OPCODE_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SET_ABS = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SET_REL = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_RUN     = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_BRAKE   = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TICKS   = 2'd1;

  typedef struct packed {
    logic [OPCODE_W-1:0]     opcode;
    logic signed [POS_W-1:0] position_value;
  } cmd_t;

  typedef struct packed {
    logic                    step_out;
    logic                    dir_out;
    logic                    busy_res;
    logic                    reached;
    logic signed [POS_W-1:0] current_position;
  } result_t;

  typedef struct packed {
    logic [TICK_W-1:0] period_ticks;
    logic [TICK_W-1:0] high_ticks;
  } cfg_t;

endpackage

[hw/rtl/spc_cfg.sv]
// configuration registers: step period and step high time
// depends on spc_pkg
module spc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [spc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [spc_pkg::TICK_W-1:0]    wr_data,
  output spc_pkg::cfg_t                 cfg
);

  logic [spc_pkg::TICK_W-1:0] period_ticks;
  logic [spc_pkg::TICK_W-1:0] high_ticks;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks <= spc_pkg::PERIOD_RESET;
      high_ticks   <= spc_pkg::HIGH_RESET;
    end else if (wr_en) begin
      case (wr_index)
        spc_pkg::REG_PERIOD_TICKS: period_ticks <= wr_data;
        spc_pkg::REG_HIGH_TICKS:   high_ticks   <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg.period_ticks = period_ticks;
  assign cfg.high_ticks   = high_ticks;

endmodule

[hw/rtl/spc_core.sv]
// motion state and single-pass command logic of the stepper controller
// depends on spc_pkg; result is registered in the top level
module spc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  spc_pkg::cmd_t    cmd,
  input  spc_pkg::cfg_t    cfg,
  output spc_pkg::result_t result
);

  logic signed [spc_pkg::POS_W-1:0] position_count, position_count_next;
  logic signed [spc_pkg::POS_W-1:0] target_count, target_count_next;
  logic                             moving, moving_next;
  logic                             direction, direction_next;
  logic [spc_pkg::TICK_W-1:0]       period_counter, period_counter_next;

  logic [spc_pkg::TICK_W-1:0]       active_period;
  logic [spc_pkg::TICK_W-1:0]       counter_inc;
  logic signed [spc_pkg::POS_W-1:0] pos_up;
  logic signed [spc_pkg::POS_W-1:0] pos_dn;
  logic                             level_now;
  logic                             step;
  logic                             hit;

  // period floor and shared arithmetic
  assign active_period = (cfg.period_ticks < spc_pkg::MIN_PERIOD_TICKS)
                         ? spc_pkg::MIN_PERIOD_TICKS : cfg.period_ticks;
  assign counter_inc   = period_counter + spc_pkg::TICK_W'(1);
  assign pos_up        = position_count + spc_pkg::POS_W'(1);
  assign pos_dn        = position_count - spc_pkg::POS_W'(1);
  assign level_now     = moving && (period_counter < cfg.high_ticks);

  // next state per command
  always_comb begin
    position_count_next = position_count;
    target_count_next   = target_count;
    moving_next         = moving;
    direction_next      = direction;
    period_counter_next = period_counter;
    step                = level_now;
    hit                 = 1'b0;
    case (cmd.opcode)
      spc_pkg::OP_TICK: begin
        if (moving) begin
          if (counter_inc >= active_period) begin
            period_counter_next = '0;
            if (direction) begin
              position_count_next = pos_dn;
              if (!(target_count < pos_dn)) begin
                moving_next = 1'b0;
                hit         = 1'b1;
              end
            end else begin
              position_count_next = pos_up;
              if (!(pos_up < target_count)) begin
                moving_next = 1'b0;
                hit         = 1'b1;
              end
            end
          end else begin
            period_counter_next = counter_inc;
          end
        end
      end
      spc_pkg::OP_SET_ABS: begin
        if (!moving) target_count_next = cmd.position_value;
      end
      spc_pkg::OP_SET_REL: begin
        if (!moving) target_count_next = position_count + cmd.position_value;
      end
      spc_pkg::OP_RUN: begin
        if (!moving && (target_count != position_count)) begin
          direction_next      = (target_count < position_count);
          moving_next         = 1'b1;
          period_counter_next = '0;
          step                = (cfg.high_ticks != '0);
        end
      end
      spc_pkg::OP_BRAKE: begin
        moving_next         = 1'b0;
        period_counter_next = '0;
        step                = 1'b0;
      end
      default: ;
    endcase
  end

  // state update on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      target_count   <= '0;
      moving         <= 1'b0;
      direction      <= 1'b0;
      period_counter <= '0;
    end else if (accept) begin
      position_count <= position_count_next;
      target_count   <= target_count_next;
      moving         <= moving_next;
      direction      <= direction_next;
      period_counter <= period_counter_next;
    end
  end

  assign result.step_out         = step;
  assign result.dir_out          = direction_next;
  assign result.busy_res         = moving_next;
  assign result.reached          = hit;
  assign result.current_position = position_count_next;

endmodule

[hw/rtl/stepper_position_controller_top.sv]
// Stepper position controller, top level: handshakes and result register.
// Result: registered, its beat valid in the cycle after the command beat is accepted.
// Throughput: one command per cycle unless out_ready stalls; the motion
// state updates in a single pass, the result register frees when its beat is taken.
// Reset: synchronous, clears the motion state and the result valid;
// registers return to period 1000 and high time 100.
module stepper_position_controller_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  spc_pkg::cmd_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output spc_pkg::result_t              out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spc_pkg::TICK_W-1:0]    cfg_data
);

  spc_pkg::cfg_t    cfg;
  spc_pkg::result_t result;
  logic             accept;

  // take a beat whenever the result register is empty or draining
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  spc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  spc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (in_data),
    .cfg    (cfg),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  // checks
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

  a_empty_takes_beat: assert property (@(posedge clk)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

  a_reached_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.reached |-> !out_data.busy_res)
    else $error("target reached but still busy");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_reached_on_tick: assert property (@(posedge clk) disable iff (rst)
    accept && result.reached |-> in_data.opcode == spc_pkg::OP_TICK)
    else $error("reached flagged on a non-tick command");

endmodule
